/* design/bbps_pkg.sv */
// ============================================================================
// bbps_pkg
// Shared types, codes and defaults of the buzzer beep pattern sequencer.
// ============================================================================
package bbps_pkg;

  // default widths of the tick countdown and the beep count
  localparam int TIMER_WIDTH_DEF = 16;
  localparam int COUNT_WIDTH_DEF = 8;

  // request codes
  localparam logic [1:0] REQ_TICK = 2'd0;
  localparam logic [1:0] REQ_POLL = 2'd1;
  localparam logic [1:0] REQ_CMD  = 2'd2;

  // command modes
  localparam logic [1:0] MODE_STOP  = 2'd0;
  localparam logic [1:0] MODE_SHORT = 2'd1;
  localparam logic [1:0] MODE_HALF  = 2'd2;
  localparam logic [1:0] MODE_LONG  = 2'd3;

  // configuration register indexes
  localparam int CFG_IDX_W    = 3;
  localparam int NUM_CFG_REGS = 6;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_ON  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_GAP = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_ON   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_GAP  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_ON   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_GAP  = 3'd5;

  localparam int CFG_DATA_W = 16;

  typedef logic [CFG_DATA_W-1:0] cfg_word_t;

  localparam cfg_word_t CFG_RESET [NUM_CFG_REGS] = '{
    16'd100, 16'd100, 16'd500, 16'd500, 16'd1000, 16'd1000
  };

  typedef struct packed {
    cfg_word_t short_on;
    cfg_word_t short_gap;
    cfg_word_t half_on;
    cfg_word_t half_gap;
    cfg_word_t long_on;
    cfg_word_t long_gap;
  } timing_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [1:0] cmd_mode;
    logic [7:0] beep_count;
  } in_item_t;

  typedef struct packed {
    logic       buzz_drive;
    logic       busy_res;
    logic [7:0] beeps_left;
  } out_item_t;

endpackage

/* design/bbps_in_if.sv */
// ============================================================================
// bbps_in_if
// Request channel: tick, poll or command, valid/ready handshake.
// ============================================================================
interface bbps_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [1:0] cmd_mode;
  logic [7:0] beep_count;

  modport source (output valid, req_type, cmd_mode, beep_count, input ready);
  modport sink   (input valid, req_type, cmd_mode, beep_count, output ready);
endinterface

/* design/bbps_out_if.sv */
// ============================================================================
// bbps_out_if
// Result channel: buzzer level, busy flag and beeps left.
// ============================================================================
interface bbps_out_if;
  logic       valid;
  logic       ready;
  logic       buzz_drive;
  logic       busy_res;
  logic [7:0] beeps_left;

  modport source (output valid, buzz_drive, busy_res, beeps_left, input ready);
  modport sink   (input valid, buzz_drive, busy_res, beeps_left, output ready);
endinterface

/* design/bbps_cfg_if.sv */
// ============================================================================
// bbps_cfg_if
// Configuration write channel: register index and write data.
// ============================================================================
interface bbps_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* design/bbps_cfg_regs.sv */
// ============================================================================
// bbps_cfg_regs
// Beep timing registers, written through the configuration channel.
// ============================================================================
module bbps_cfg_regs (
  input  logic              clk,
  input  logic              rst_n,
  bbps_cfg_if.sink          cfg,
  output bbps_pkg::timing_t timing
);
  import bbps_pkg::*;

  cfg_word_t regs_r [NUM_CFG_REGS];

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CFG_REGS; i++) begin
        regs_r[i] <= CFG_RESET[i];
      end
    end else if (cfg.valid && cfg.ready &&
                 (32'(cfg.index) < 32'(NUM_CFG_REGS))) begin
      regs_r[cfg.index] <= cfg.data;
    end
  end

  assign timing.short_on  = regs_r[CFG_SHORT_ON];
  assign timing.short_gap = regs_r[CFG_SHORT_GAP];
  assign timing.half_on   = regs_r[CFG_HALF_ON];
  assign timing.half_gap  = regs_r[CFG_HALF_GAP];
  assign timing.long_on   = regs_r[CFG_LONG_ON];
  assign timing.long_gap  = regs_r[CFG_LONG_GAP];

endmodule

/* design/bbps_seq_core.sv */
// ============================================================================
// bbps_seq_core
// Pattern state machine, beep count and tick countdown; one step per item.
// ============================================================================
module bbps_seq_core #(
  parameter int TIMER_WIDTH = bbps_pkg::TIMER_WIDTH_DEF,
  parameter int COUNT_WIDTH = bbps_pkg::COUNT_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_en,
  input  bbps_pkg::in_item_t  item,
  input  bbps_pkg::timing_t   timing,
  output bbps_pkg::out_item_t result
);
  import bbps_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE        = 4'd0,
    ST_SHORT_START = 4'd1,
    ST_SHORT_ON    = 4'd2,
    ST_SHORT_GAP   = 4'd3,
    ST_HALF_START  = 4'd4,
    ST_HALF_ON     = 4'd5,
    ST_HALF_GAP    = 4'd6,
    ST_LONG_START  = 4'd7,
    ST_LONG_ON     = 4'd8,
    ST_LONG_GAP    = 4'd9,
    ST_STOP        = 4'd10
  } state_t;

  typedef enum logic [1:0] {PH_NONE, PH_START, PH_ON, PH_GAP} phase_t;

  state_t                 state_r, state_nxt;
  logic [COUNT_WIDTH-1:0] rem_r, rem_nxt;
  logic [TIMER_WIDTH-1:0] cd_r, cd_nxt;
  logic                   drive_r, drive_nxt;

  cfg_word_t on_time, gap_time;
  state_t    start_st, on_st, gap_st;
  phase_t    phase;

  // mode of the current state: its timing and its three states
  always_comb begin
    unique case (state_r)
      ST_HALF_START, ST_HALF_ON, ST_HALF_GAP: begin
        on_time  = timing.half_on;
        gap_time = timing.half_gap;
        start_st = ST_HALF_START;
        on_st    = ST_HALF_ON;
        gap_st   = ST_HALF_GAP;
      end
      ST_LONG_START, ST_LONG_ON, ST_LONG_GAP: begin
        on_time  = timing.long_on;
        gap_time = timing.long_gap;
        start_st = ST_LONG_START;
        on_st    = ST_LONG_ON;
        gap_st   = ST_LONG_GAP;
      end
      default: begin
        on_time  = timing.short_on;
        gap_time = timing.short_gap;
        start_st = ST_SHORT_START;
        on_st    = ST_SHORT_ON;
        gap_st   = ST_SHORT_GAP;
      end
    endcase
  end

  always_comb begin
    unique case (state_r)
      ST_SHORT_START, ST_HALF_START, ST_LONG_START: phase = PH_START;
      ST_SHORT_ON, ST_HALF_ON, ST_LONG_ON:          phase = PH_ON;
      ST_SHORT_GAP, ST_HALF_GAP, ST_LONG_GAP:       phase = PH_GAP;
      default:                                      phase = PH_NONE;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    rem_nxt   = rem_r;
    cd_nxt    = cd_r;
    drive_nxt = drive_r;
    unique case (item.req_type)
      REQ_TICK: begin
        if (cd_r != '0) begin
          cd_nxt = cd_r - 1'b1;
        end
      end
      REQ_POLL: begin
        if (state_r != ST_IDLE) begin
          unique case (phase)
            PH_START: begin
              if (rem_r != '0) begin
                drive_nxt = 1'b1;
                cd_nxt    = TIMER_WIDTH'(on_time);
                state_nxt = on_st;
              end else begin
                state_nxt = ST_STOP;
              end
            end
            PH_ON: begin
              if (cd_r == '0) begin
                drive_nxt = 1'b0;
                cd_nxt    = TIMER_WIDTH'(gap_time);
                state_nxt = gap_st;
              end
            end
            PH_GAP: begin
              if (cd_r == '0) begin
                if (rem_r != '0) begin
                  rem_nxt = rem_r - 1'b1;
                end
                state_nxt = start_st;
              end
            end
            default: begin
              // stopping (and any stray code): silence and go idle
              drive_nxt = 1'b0;
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      REQ_CMD: begin
        rem_nxt = COUNT_WIDTH'(item.beep_count);
        unique case (item.cmd_mode)
          MODE_SHORT: state_nxt = ST_SHORT_START;
          MODE_HALF:  state_nxt = ST_HALF_START;
          MODE_LONG:  state_nxt = ST_LONG_START;
          default:    state_nxt = ST_STOP;
        endcase
      end
      default: ; // unknown request: no change
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      rem_r   <= '0;
      cd_r    <= '0;
      drive_r <= 1'b0;
    end else if (step_en) begin
      state_r <= state_nxt;
      rem_r   <= rem_nxt;
      cd_r    <= cd_nxt;
      drive_r <= drive_nxt;
    end
  end

  assign result.buzz_drive = drive_nxt;
  assign result.busy_res   = (state_nxt != ST_IDLE);
  assign result.beeps_left = 8'(rem_nxt);

`ifndef SYNTHESIS
  a_idle_silent: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !drive_r)
    else $error("buzzer driven while idle");

  a_count_no_rise: assert property (@(posedge clk) disable iff (!rst_n)
    !(step_en && item.req_type == REQ_CMD) |=> rem_r <= $past(rem_r))
    else $error("beep count rose without a command");

  a_tick_dec: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && item.req_type == REQ_TICK && cd_r != '0
    |=> cd_r == TIMER_WIDTH'($past(cd_r) - 1'b1))
    else $error("tick did not decrement countdown");
`endif

endmodule

/* design/buzzer_beep_pattern_sequencer.sv */
// ============================================================================
// buzzer_beep_pattern_sequencer
// Tick/poll/command driven beep pattern generator with result channel.
// ============================================================================
// Path: an accepted request is held in the input register, takes one step of
//   the pattern machine, and its result is held in the result register.
// Throughput: one request per cycle while out_if does not stall.
// Reset (rst_n low, synchronous): pattern idle, beep count and countdown zero,
//   buzzer off, both channel stages empty, timing registers at their defaults.
module buzzer_beep_pattern_sequencer #(
  parameter int TIMER_WIDTH = bbps_pkg::TIMER_WIDTH_DEF,
  parameter int COUNT_WIDTH = bbps_pkg::COUNT_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  bbps_in_if.sink    in_if,
  bbps_out_if.source out_if,
  bbps_cfg_if.sink   cfg_if
);
  import bbps_pkg::*;

  // input stage
  in_item_t  item_r;
  logic      in_v_r;
  // result stage
  out_item_t res_r;
  logic      out_v_r;

  timing_t   timing;
  out_item_t step_res;
  logic      step_en;

  // The input stage moves on whenever the result stage is empty or is
  // being drained this cycle; the pattern machine steps on that same move,
  // so every item sees the state that the item before it left.
  assign step_en     = in_v_r && (!out_v_r || out_if.ready);
  assign in_if.ready = !in_v_r || step_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_if.ready) begin
        in_v_r <= in_if.valid;
      end
      if (step_en) begin
        out_v_r <= 1'b1;
      end else if (out_if.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_if.ready && in_if.valid) begin
      item_r.req_type   <= in_if.req_type;
      item_r.cmd_mode   <= in_if.cmd_mode;
      item_r.beep_count <= in_if.beep_count;
    end
    if (step_en) begin
      res_r <= step_res;
    end
  end

  bbps_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_if),
    .timing (timing)
  );

  bbps_seq_core #(
    .TIMER_WIDTH (TIMER_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .item    (item_r),
    .timing  (timing),
    .result  (step_res)
  );

  assign out_if.valid      = out_v_r;
  assign out_if.buzz_drive = res_r.buzz_drive;
  assign out_if.busy_res   = res_r.busy_res;
  assign out_if.beeps_left = res_r.beeps_left;

`ifndef SYNTHESIS
  a_step_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    step_en |=> out_v_r)
    else $error("stepped item did not reach the result stage");

  a_no_silent_drop: assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r && !step_en |=> in_v_r)
    else $error("pending request lost");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_if.ready |=> out_v_r && $stable(res_r))
    else $error("stalled result changed or dropped");
`endif

endmodule
